// File: src/brq4_pkg.sv
// Shared constants and types of the bilinear Q12.4 remap block.
// No dependencies; imported by the top level and its port checker.
`default_nettype none

package brq4_pkg;

	// Source store geometry
	localparam int MAX_COLS   = 256;
	localparam int MAX_ROWS   = 256;
	localparam int COL_W      = $clog2(MAX_COLS);
	localparam int ROW_W      = $clog2(MAX_ROWS);
	localparam int BCOL_W     = COL_W - 1;
	localparam int BROW_W     = ROW_W - 1;
	localparam int BANK_AW    = BROW_W + BCOL_W;
	localparam int BANK_DEPTH = 1 << BANK_AW;
	localparam int NUM_BANKS  = 4;

	// Size registers and coordinate compare width
	localparam int CFG_W = 9;
	localparam int CNT_W = 13;

	// Command codes
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_REMAP = 1'b1;

	// Register indexes
	localparam logic REG_COLS = 1'b0;
	localparam logic REG_ROWS = 1'b1;

	localparam logic [CFG_W-1:0] SIZE_RESET = 9'd256;

	typedef logic [7:0] pixel_t;
	typedef logic [8:0] weight_t;
	typedef logic [15:0] product_t;

	localparam pixel_t PIX_OUTSIDE = 8'hFF;

endpackage

`default_nettype wire

// File: src/bilinear_remap_q4_coords.sv
// Bilinear remap of an 8-bit source image with signed Q12.4 coordinates.
// Depends on brq4_pkg for geometry, codes and types.
//
// Usage:
//   One request channel (in_valid/in_ready) carries either a load request
//   (command = load: write load_value at load_row/load_col) or a remap request
//   (command = remap: blend the four pixels around map_u/map_v). A remap
//   yields one result on out_valid/out_ready; a load yields none.
//   The source store is split into four banks by row and column parity, so
//   the four neighbors of any coordinate sit in four different banks and are
//   read together. A request enters every cycle while in_ready is high.
//   A remap passes the bank read registers, the weighted product registers
//   and the output register, which takes their sum.
//   Throughput: one request per cycle while in_ready is high, set by the
//   single read port per bank.
//   A load followed by a remap of the same pixel in the next cycle sees the
//   new value: the write lands at the edge before the read.
//   Outside coordinates answer out_pixel = 255 with outside = 1.
//   Reset clears the pipeline valids and sets both size registers to 256;
//   the store itself is not cleared, so read only pixels already loaded.
//   When the receiver stalls, the output register holds; bubbles in the
//   pipeline still close up, and in_ready falls only once every stage is full.
//   Only write size registers on cfg_we with no remap in flight; not enforced.
`default_nettype none

module bilinear_remap_q4_coords
	import brq4_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	// configuration write port
	input  wire logic               cfg_we,
	input  wire logic               cfg_index,
	input  wire logic [CFG_W-1:0]   cfg_wdata,
	// request channel
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               command,
	input  wire logic [7:0]         load_row,
	input  wire logic [7:0]         load_col,
	input  wire logic [7:0]         load_value,
	input  wire logic signed [15:0] map_u,
	input  wire logic signed [15:0] map_v,
	// result channel
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [7:0]              out_pixel,
	output logic                    outside
);

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic [CFG_W-1:0] cols_q;
	logic [CFG_W-1:0] rows_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= SIZE_RESET;
			rows_q <= SIZE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COLS: cols_q <= cfg_wdata;
				REG_ROWS: rows_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Pipeline flow control: each stage advances when the next one is
	// empty or advancing itself.
	// ---------------------------------------------------------------
	logic v_s1, v_s2, out_valid_q;
	logic out_en, s2_en, s1_en;
	logic accept, rd_en, wr_en;

	assign out_en   = !out_valid_q || out_ready;
	assign s2_en    = !v_s2 || out_en;
	assign s1_en    = !v_s1 || s2_en;
	assign in_ready = s1_en;
	assign accept   = in_valid && s1_en;
	assign rd_en    = accept && (command == CMD_REMAP);
	assign wr_en    = accept && (command == CMD_LOAD)
		&& (32'(load_row) < MAX_ROWS) && (32'(load_col) < MAX_COLS);

	// ---------------------------------------------------------------
	// Stage 0: range check, fractions, weights and bank addresses
	// ---------------------------------------------------------------
	logic [CNT_W-1:0]  eff_cols, eff_rows;
	logic              inside_x, inside_y;
	logic [3:0]        dx, dy;
	logic [4:0]        ndx, ndy;
	logic [ROW_W-1:0]  row_idx;
	logic [COL_W-1:0]  col_idx;
	logic [BROW_W-1:0] brow_even, brow_odd;
	logic [BCOL_W-1:0] bcol_even, bcol_odd;
	logic [BANK_AW-1:0] raddr [NUM_BANKS];
	logic [BANK_AW-1:0] wr_addr;
	logic [ROW_W-1:0]  wr_row;
	logic [COL_W-1:0]  wr_col;
	logic [1:0]        wr_bank;
	weight_t           w00, w01, w10, w11;

	// Clamp sizes to the store; a size below two leaves no cell inside.
	assign eff_cols = (CNT_W'(cols_q) > CNT_W'(MAX_COLS)) ? CNT_W'(MAX_COLS)
		: CNT_W'(cols_q);
	assign eff_rows = (CNT_W'(rows_q) > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS)
		: CNT_W'(rows_q);

	// Integer part is bits 15..4 (a floor); inside when 0 <= c and c+1 < size.
	assign inside_x = !map_u[15] && ((CNT_W'(map_u[14:4]) + CNT_W'(1)) < eff_cols);
	assign inside_y = !map_v[15] && ((CNT_W'(map_v[14:4]) + CNT_W'(1)) < eff_rows);

	assign dx  = map_u[3:0];
	assign dy  = map_v[3:0];
	assign ndx = 5'd16 - 5'(dx);
	assign ndy = 5'd16 - 5'(dy);

	// Widen before multiplying: 16 * 16 needs all nine bits.
	assign w00 = weight_t'(ndx) * weight_t'(ndy);
	assign w01 = weight_t'(dx) * weight_t'(ndy);
	assign w10 = weight_t'(ndx) * weight_t'(dy);
	assign w11 = weight_t'(dx) * weight_t'(dy);

	assign col_idx = COL_W'(map_u[14:4]);
	assign row_idx = ROW_W'(map_v[14:4]);

	// Even bank takes c or c+1, whichever is even; odd bank likewise.
	assign brow_odd  = row_idx[ROW_W-1:1];
	assign brow_even = row_idx[ROW_W-1:1] + BROW_W'(row_idx[0]);
	assign bcol_odd  = col_idx[COL_W-1:1];
	assign bcol_even = col_idx[COL_W-1:1] + BCOL_W'(col_idx[0]);

	always_comb begin
		for (int b = 0; b < NUM_BANKS; b++) begin
			raddr[b] = {(b[1] ? brow_odd : brow_even), (b[0] ? bcol_odd : bcol_even)};
		end
	end

	assign wr_row  = ROW_W'(load_row);
	assign wr_col  = COL_W'(load_col);
	assign wr_bank = {wr_row[0], wr_col[0]};
	assign wr_addr = {wr_row[ROW_W-1:1], wr_col[COL_W-1:1]};

	// ---------------------------------------------------------------
	// Source store: four parity banks, one write or one read per cycle
	// ---------------------------------------------------------------
	pixel_t rd_s1 [NUM_BANKS];

	for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
		pixel_t mem [BANK_DEPTH];

		always_ff @(posedge clk) begin
			if (wr_en && (wr_bank == 2'(b))) begin
				mem[wr_addr] <= load_value;
			end
			if (rd_en) begin
				rd_s1[b] <= mem[raddr[b]];
			end
		end
	end

	// Stage 1 side registers
	weight_t w00_s1, w01_s1, w10_s1, w11_s1;
	logic    rpar_s1, cpar_s1, outside_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s1_en) begin
			v_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			w00_s1     <= w00;
			w01_s1     <= w01;
			w10_s1     <= w10;
			w11_s1     <= w11;
			rpar_s1    <= row_idx[0];
			cpar_s1    <= col_idx[0];
			outside_s1 <= !(inside_x && inside_y);
		end
	end

	// ---------------------------------------------------------------
	// Stage 1: route banks to neighbors, weight each pixel
	// ---------------------------------------------------------------
	pixel_t   p00, p01, p10, p11;
	product_t m00, m01, m10, m11;

	assign p00 = rd_s1[{rpar_s1, cpar_s1}];
	assign p01 = rd_s1[{rpar_s1, !cpar_s1}];
	assign p10 = rd_s1[{!rpar_s1, cpar_s1}];
	assign p11 = rd_s1[{!rpar_s1, !cpar_s1}];

	// Each product never passes 256 * 255, so 16 bits hold it.
	assign m00 = product_t'(17'(w00_s1) * 17'(p00));
	assign m01 = product_t'(17'(w01_s1) * 17'(p01));
	assign m10 = product_t'(17'(w10_s1) * 17'(p10));
	assign m11 = product_t'(17'(w11_s1) * 17'(p11));

	product_t m00_s2, m01_s2, m10_s2, m11_s2;
	logic     outside_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_en && v_s1) begin
			m00_s2     <= m00;
			m01_s2     <= m01;
			m10_s2     <= m10;
			m11_s2     <= m11;
			outside_s2 <= outside_s1;
		end
	end

	// ---------------------------------------------------------------
	// Stage 2: sum and truncate into the output register
	// ---------------------------------------------------------------
	logic [17:0] sum_s2;
	pixel_t      out_pixel_q;
	logic        outside_q;

	// Weights sum to 256, so the total never passes 255 * 256.
	assign sum_s2 = 18'(m00_s2) + 18'(m01_s2) + 18'(m10_s2) + 18'(m11_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_en) begin
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_en && v_s2) begin
			out_pixel_q <= outside_s2 ? PIX_OUTSIDE : sum_s2[15:8];
			outside_q   <= outside_s2;
		end
	end

	assign out_valid = out_valid_q;
	assign out_pixel = out_pixel_q;
	assign outside   = outside_q;

endmodule

`default_nettype wire

// File: src/brq4_chk.sv
// Port-level checker for the bilinear remap block, bound to its top level.
// Depends on brq4_pkg for the size width and the outside pixel code.
`default_nettype none

module brq4_chk
	import brq4_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               cfg_we,
	input wire logic               cfg_index,
	input wire logic [CFG_W-1:0]   cfg_wdata,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic               command,
	input wire logic [7:0]         load_row,
	input wire logic [7:0]         load_col,
	input wire logic [7:0]         load_value,
	input wire logic signed [15:0] map_u,
	input wire logic signed [15:0] map_v,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic [7:0]         out_pixel,
	input wire logic               outside
);

	// A stalled result holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_pixel) && $stable(outside))
		else $error("result changed while stalled");

	// An outside result always carries the outside pixel code.
	a_outside_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && outside |-> out_pixel == PIX_OUTSIDE)
		else $error("outside result with wrong pixel");

	// A free or draining output register never blocks new requests.
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || out_ready) |-> in_ready)
		else $error("request refused while output drains");

	// Reset empties the result channel.
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result shown during reset");

endmodule

bind bilinear_remap_q4_coords brq4_chk u_brq4_chk (.*);

`default_nettype wire
